FILE: sv/tlbp_pkg.sv
// Shared types and constants for the two-level branch predictor with BTB.
// Beat layouts, register indexes and reset values; no dependencies.
package tlbp_pkg;

  localparam int ADDR_W     = 64;
  localparam int STAMP_W    = 64;
  localparam int SIZE_W     = 4;
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int HB_W       = 5;
  localparam int CB_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_BITS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] HISTORY_BITS_RST = 4'd12;
  localparam logic [CFG_DATA_W-1:0] COUNTER_BITS_RST = 4'd2;

  typedef struct packed {
    logic [STAMP_W-1:0] cycle;
    logic [ADDR_W-1:0]  next_address;
    logic [SIZE_W-1:0]  instr_size;
    logic [ADDR_W-1:0]  branch_address;
    logic               is_branch;
  } item_t;

  typedef struct packed {
    logic actual_taken;
    logic predicted_taken;
    logic btb_hit;
    logic resolve_stage;
  } result_t;

endpackage

FILE: sv/two_level_branch_predictor_btb_unit.sv
// Top level of the two-level (global history) branch predictor with a
// set-associative BTB. Uses tlbp_pkg; BTB rows and counters sit in two
// single-port synchronous memories inside this module.
//
//   channel   | direction | handshake                     | payload
//   s_axis    | in        | s_axis_tvalid / s_axis_tready | retired instruction, is_branch in tuser
//   m_axis    | out       | m_axis_tvalid / m_axis_tready | prediction result
//   cfg       | in        | cfg_we_i                      | history_bits, counter_bits
//
// An item is read (BTB row and counter) and then resolved, writing both back;
// the next counter index depends on that write-back. After reset a clearing
// pass over max(BTB_SETS, 2**HISTORY_MAX) addresses runs (4096 by default);
// a register write reruns it for the counters only.
// A finished result waits in the output register while the next beat is
// accepted; the write-back stalls only if that register is still full.
// BTB_SETS must be a power of two.
module two_level_branch_predictor_btb_unit #(
  parameter int BTB_SETS         = 256,
  parameter int BTB_WAYS         = 4,
  parameter int HISTORY_MAX      = 12,
  parameter int COUNTER_MAX_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // branch_address, instr_size, next_address, cycle, zero fill
  input  logic [tlbp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // is_branch
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // resolve_stage, btb_hit, predicted_taken, actual_taken, zero fill
  output logic [tlbp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [tlbp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tlbp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SET_W     = $clog2(BTB_SETS);
  localparam int IDX_W     = (SET_W > 0) ? SET_W : 1;
  localparam int TAG_W     = tlbp_pkg::ADDR_W - SET_W;
  localparam int ENT_W     = TAG_W + tlbp_pkg::STAMP_W;
  localparam int WAY_W     = (BTB_WAYS > 1) ? $clog2(BTB_WAYS) : 1;
  localparam int WAYS_P2   = 1 << $clog2(BTB_WAYS);
  localparam int PHT_DEPTH = 1 << HISTORY_MAX;
  localparam int CNT_W     = COUNTER_MAX_BITS;
  localparam int CLR_N     = (BTB_SETS > PHT_DEPTH) ? BTB_SETS : PHT_DEPTH;
  localparam int CLR_W     = ($clog2(CLR_N) > 0) ? $clog2(CLR_N) : 1;
  localparam int SW        = tlbp_pkg::STAMP_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef logic [BTB_WAYS-1:0][ENT_W-1:0] row_t;

  state_e                          state_q;
  logic [CLR_W-1:0]                clr_cnt_q;
  logic                            clr_btb_q;
  logic [tlbp_pkg::CFG_DATA_W-1:0] hist_bits_q;
  logic [tlbp_pkg::CFG_DATA_W-1:0] cnt_bits_q;
  logic [HISTORY_MAX-1:0]          history_q;
  logic [HISTORY_MAX-1:0]          history_d;
  logic                            m_valid_q;
  logic                            m_valid_d;
  tlbp_pkg::result_t               m_data_q;
  tlbp_pkg::result_t               result_d;

  tlbp_pkg::item_t                 in_item;
  tlbp_pkg::item_t                 item_q;
  logic [IDX_W-1:0]                set_q;
  logic [HISTORY_MAX-1:0]          pht_idx_q;

  row_t                            btb_mem_q [BTB_SETS];
  row_t                            btb_rd_q;
  logic [CNT_W-1:0]                pht_mem_q [PHT_DEPTH];
  logic [CNT_W-1:0]                pht_rd_q;

  logic [tlbp_pkg::HB_W-1:0]       hb_eff;
  logic [tlbp_pkg::CB_W-1:0]       cb_eff;
  logic [HISTORY_MAX-1:0]          hmask;
  logic [CNT_W-1:0]                cmax;
  logic [CNT_W-1:0]                half;

  logic                            accept;
  logic                            out_free;
  logic                            finish;
  logic                            cfg_wr;
  logic                            clr_last;
  logic                            clr_pht_on;
  logic                            clr_btb_on;

  logic [TAG_W-1:0]                tag;
  logic                            hit;
  logic [WAY_W-1:0]                hit_way;
  logic [WAY_W-1:0]                victim;
  logic [SW-1:0]                   nd_stamp [1:2*WAYS_P2-1];
  logic                            nd_vld   [1:2*WAYS_P2-1];
  logic [WAY_W-1:0]                nd_way   [1:2*WAYS_P2-1];
  row_t                            row_new;
  logic                            taken;
  logic                            pred;
  logic [CNT_W-1:0]                cnt_new;

  logic                            btb_we;
  logic [IDX_W-1:0]                btb_waddr;
  row_t                            btb_wdata;
  logic                            pht_we;
  logic [HISTORY_MAX-1:0]          pht_waddr;
  logic [CNT_W-1:0]                pht_wdata;

  assign in_item       = tlbp_pkg::item_t'({s_axis_tdata[$bits(tlbp_pkg::item_t)-2:0],
                                            s_axis_tuser});
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign finish        = (state_q == ST_EXEC) && out_free;
  assign cfg_wr        = cfg_we_i && ((cfg_idx_i == tlbp_pkg::REG_HISTORY_BITS) ||
                                      (cfg_idx_i == tlbp_pkg::REG_COUNTER_BITS));
  assign m_valid_d     = (finish && !cfg_wr) || (m_valid_q && !m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(tlbp_pkg::OUT_DATA_W - $bits(tlbp_pkg::result_t)){1'b0}}, m_data_q};

  assign clr_last   = (clr_cnt_q == CLR_W'(CLR_N - 1));
  assign clr_pht_on = (state_q == ST_CLEAR) && ({1'b0, clr_cnt_q} < (CLR_W + 1)'(PHT_DEPTH));
  assign clr_btb_on = (state_q == ST_CLEAR) && clr_btb_q &&
                      ({1'b0, clr_cnt_q} < (CLR_W + 1)'(BTB_SETS));

  // effective register settings
  always_comb begin
    if (hist_bits_q == '0) begin
      hb_eff = tlbp_pkg::HB_W'(1);
    end else if ({1'b0, hist_bits_q} > tlbp_pkg::HB_W'(HISTORY_MAX)) begin
      hb_eff = tlbp_pkg::HB_W'(HISTORY_MAX);
    end else begin
      hb_eff = {1'b0, hist_bits_q};
    end
    if (cnt_bits_q == '0) begin
      cb_eff = tlbp_pkg::CB_W'(1);
    end else if (cnt_bits_q > tlbp_pkg::CB_W'(COUNTER_MAX_BITS)) begin
      cb_eff = tlbp_pkg::CB_W'(COUNTER_MAX_BITS);
    end else begin
      cb_eff = cnt_bits_q;
    end
    hmask = HISTORY_MAX'((32'd1 << hb_eff) - 32'd1);
    cmax  = CNT_W'((9'd1 << cb_eff) - 9'd1);
    half  = CNT_W'(9'd1 << (cb_eff - tlbp_pkg::CB_W'(1)));
  end

  // BTB lookup, victim tree and counter update
  always_comb begin
    tag     = TAG_W'(item_q.branch_address / BTB_SETS);
    hit     = 1'b0;
    hit_way = '0;
    for (int w = BTB_WAYS - 1; w >= 0; w--) begin
      if (btb_rd_q[w][ENT_W-1:SW] == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end

    for (int i = 0; i < WAYS_P2; i++) begin
      if (i < BTB_WAYS) begin
        nd_stamp[WAYS_P2 + i] = btb_rd_q[i][SW-1:0];
        nd_vld[WAYS_P2 + i]   = 1'b1;
      end else begin
        nd_stamp[WAYS_P2 + i] = '1;
        nd_vld[WAYS_P2 + i]   = 1'b0;
      end
      nd_way[WAYS_P2 + i] = WAY_W'(i);
    end
    for (int n = WAYS_P2 - 1; n >= 1; n--) begin
      if (nd_vld[2*n+1] && (!nd_vld[2*n] || (nd_stamp[2*n+1] <= nd_stamp[2*n]))) begin
        nd_stamp[n] = nd_stamp[2*n+1];
        nd_vld[n]   = nd_vld[2*n+1];
        nd_way[n]   = nd_way[2*n+1];
      end else begin
        nd_stamp[n] = nd_stamp[2*n];
        nd_vld[n]   = nd_vld[2*n];
        nd_way[n]   = nd_way[2*n];
      end
    end
    victim = nd_way[1];

    row_new = btb_rd_q;
    if (hit) begin
      row_new[hit_way][SW-1:0] = item_q.cycle;
    end else begin
      row_new[victim] = {tag, item_q.cycle};
    end

    taken = (item_q.branch_address + {{(tlbp_pkg::ADDR_W - tlbp_pkg::SIZE_W){1'b0}},
             item_q.instr_size}) != item_q.next_address;
    pred  = (pht_rd_q >= half);
    cnt_new = (pht_rd_q > cmax) ? cmax : pht_rd_q;
    if (taken) begin
      if (cnt_new < cmax) cnt_new = cnt_new + CNT_W'(1);
    end else begin
      if (cnt_new != '0) cnt_new = cnt_new - CNT_W'(1);
    end
    history_d = HISTORY_MAX'({history_q, taken}) & hmask;

    result_d.resolve_stage   = item_q.is_branch && taken && (!hit || !pred);
    result_d.btb_hit         = item_q.is_branch && hit;
    result_d.predicted_taken = item_q.is_branch && pred;
    result_d.actual_taken    = item_q.is_branch && taken;
  end

  // memory write selection
  always_comb begin
    btb_we    = clr_btb_on || (finish && item_q.is_branch);
    btb_waddr = clr_btb_on ? IDX_W'(clr_cnt_q) : set_q;
    btb_wdata = clr_btb_on ? '0 : row_new;
    pht_we    = clr_pht_on || (finish && item_q.is_branch);
    pht_waddr = clr_pht_on ? HISTORY_MAX'(clr_cnt_q) : pht_idx_q;
    pht_wdata = clr_pht_on ? half : cnt_new;
  end

  always_ff @(posedge clk_i) begin
    if (btb_we) begin
      btb_mem_q[btb_waddr] <= btb_wdata;
    end
    if (accept) begin
      btb_rd_q <= btb_mem_q[IDX_W'(in_item.branch_address % BTB_SETS)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pht_we) begin
      pht_mem_q[pht_waddr] <= pht_wdata;
    end
    if (accept) begin
      pht_rd_q <= pht_mem_q[history_q & hmask];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q    <= in_item;
      set_q     <= IDX_W'(in_item.branch_address % BTB_SETS);
      pht_idx_q <= history_q & hmask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_btb_q   <= 1'b1;
      hist_bits_q <= tlbp_pkg::HISTORY_BITS_RST;
      cnt_bits_q  <= tlbp_pkg::COUNTER_BITS_RST;
      history_q   <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      if (cfg_wr) begin
        if (cfg_idx_i == tlbp_pkg::REG_HISTORY_BITS) begin
          hist_bits_q <= cfg_data_i;
        end else begin
          cnt_bits_q <= cfg_data_i;
        end
        history_q <= '0;
        clr_cnt_q <= '0;
        state_q   <= ST_CLEAR;
      end else begin
        case (state_q)
          ST_CLEAR: begin
            clr_cnt_q <= clr_cnt_q + CLR_W'(1);
            if (clr_last) begin
              clr_btb_q <= 1'b0;
              state_q   <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (accept) begin
              state_q <= ST_EXEC;
            end
          end
          ST_EXEC: begin
            if (out_free) begin
              m_data_q <= result_d;
              if (item_q.is_branch) begin
                history_q <= history_d;
              end
              state_q <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i |=> !s_axis_tready)
    else $error("beat accepted while previous one still resolving");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && !cfg_we_i |=> m_axis_tvalid && (state_q == ST_IDLE))
    else $error("resolved beat did not reach output register");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == tlbp_pkg::REG_HISTORY_BITS) |=>
      (state_q == ST_CLEAR) && (history_q == '0) && (clr_cnt_q == '0))
    else $error("register write did not restart counter clearing");

  a_nonbranch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && !item_q.is_branch |-> !btb_we && !pht_we && (result_d == '0))
    else $error("non-branch changed state or gave nonzero result");
`endif

endmodule

FILE: bench/two_level_branch_predictor_btb_checker.sv
// Scoreboard for the two-level branch predictor with BTB: watches both stream
// channels and the register port, predicts every result beat and compares it.
// Depends on tlbp_pkg for beat layouts and register indexes.
`timescale 1ns / 1ps

module two_level_branch_predictor_btb_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // branch_address, instr_size, next_address, cycle, zero fill
  input  logic [tlbp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // is_branch
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // resolve_stage, btb_hit, predicted_taken, actual_taken, zero fill
  input  logic [tlbp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [tlbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlbp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             results_o,
  output int                             hits_o,
  output int                             late_o
);

  localparam int SETS      = 256;
  localparam int WAYS      = 4;
  localparam int HIST_MAX  = 12;
  localparam int CTR_MAX   = 8;
  localparam int ADDR_W    = tlbp_pkg::ADDR_W;
  localparam int SET_BITS  = $clog2(SETS);
  localparam int TAG_W     = ADDR_W - SET_BITS;
  localparam int BTB_DEPTH = SETS * WAYS;
  localparam int PHT_DEPTH = 1 << HIST_MAX;

  logic [TAG_W-1:0]                tag_mem   [BTB_DEPTH];
  logic [tlbp_pkg::STAMP_W-1:0]    stamp_mem [BTB_DEPTH];
  logic [7:0]                      ctr_mem   [PHT_DEPTH];
  logic [HIST_MAX-1:0]             ghist;
  logic [tlbp_pkg::CFG_DATA_W-1:0] hist_len_reg;
  logic [tlbp_pkg::CFG_DATA_W-1:0] ctr_len_reg;

  tlbp_pkg::result_t outcomes [$];
  int n_err, n_results, n_hits, n_late;

  function automatic int hist_len();
    if (hist_len_reg == 0) return 1;
    if (hist_len_reg > HIST_MAX) return HIST_MAX;
    return int'(hist_len_reg);
  endfunction

  function automatic int ctr_len();
    if (ctr_len_reg == 0) return 1;
    if (ctr_len_reg > CTR_MAX) return CTR_MAX;
    return int'(ctr_len_reg);
  endfunction

  function automatic string field_name(input int f);
    case (f)
      0:       return "resolve_stage";
      1:       return "btb_hit";
      2:       return "predicted_taken";
      default: return "actual_taken";
    endcase
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    n_err++;
  endtask

  task automatic clear_counters();
    logic [7:0] half;
    half = 8'(1 << (ctr_len() - 1));
    for (int i = 0; i < PHT_DEPTH; i++) ctr_mem[i] = half;
    ghist = '0;
  endtask

  task automatic predict_outcome(input tlbp_pkg::item_t instr, output tlbp_pkg::result_t r);
    logic [ADDR_W-1:0]            seq;
    logic [TAG_W-1:0]             tag;
    logic [tlbp_pkg::STAMP_W-1:0] best;
    logic [HIST_MAX-1:0]          hmask;
    logic                         taken, hit, pred;
    int                           base, victim, idx, cb, c, cmax;
    r = '0;
    if (instr.is_branch) begin
      seq   = instr.branch_address + ADDR_W'(instr.instr_size);
      taken = seq != instr.next_address;
      tag   = instr.branch_address[ADDR_W-1:SET_BITS];
      base  = int'(instr.branch_address[SET_BITS-1:0]) * WAYS;
      hit   = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        if (!hit && tag_mem[base+w] == tag) begin
          hit = 1'b1;
          stamp_mem[base+w] = instr.cycle;
        end
      end
      if (!hit) begin
        best   = '1;
        victim = 0;
        for (int w = 0; w < WAYS; w++) begin
          if (stamp_mem[base+w] <= best) begin
            best   = stamp_mem[base+w];
            victim = w;
          end
        end
        tag_mem[base+victim]   = tag;
        stamp_mem[base+victim] = instr.cycle;
      end
      cb    = ctr_len();
      hmask = HIST_MAX'((1 << hist_len()) - 1);
      idx   = int'(ghist & hmask);
      cmax  = (1 << cb) - 1;
      c     = int'(ctr_mem[idx]);
      pred  = c >= (1 << (cb - 1));
      if (c > cmax) c = cmax;
      if (taken) begin
        if (c < cmax) c++;
      end else begin
        if (c > 0) c--;
      end
      ctr_mem[idx] = 8'(c);
      ghist = ((ghist << 1) | HIST_MAX'(taken)) & hmask;
      r.actual_taken    = taken;
      r.predicted_taken = pred;
      r.btb_hit         = hit;
      r.resolve_stage   = taken && (!hit || pred != taken);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    tlbp_pkg::item_t   instr;
    tlbp_pkg::result_t got;
    tlbp_pkg::result_t want;
    if (!rst_ni) begin
      hist_len_reg = tlbp_pkg::HISTORY_BITS_RST;
      ctr_len_reg  = tlbp_pkg::COUNTER_BITS_RST;
      for (int i = 0; i < BTB_DEPTH; i++) begin
        tag_mem[i]   = '0;
        stamp_mem[i] = '0;
      end
      clear_counters();
      outcomes.delete();
      n_err     = 0;
      n_results = 0;
      n_hits    = 0;
      n_late    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(tlbp_pkg::result_t)-1:0];
        n_results++;
        if (outcomes.size() == 0) begin
          report($sformatf("result %0d arrived with no instruction outstanding", n_results));
        end else begin
          want = outcomes.pop_front();
          for (int f = 0; f < $bits(tlbp_pkg::result_t); f++) begin
            if (got[f] !== want[f])
              report($sformatf("result %0d: %s is %b, expected %b",
                               n_results, field_name(f), got[f], want[f]));
          end
          if (want.btb_hit) n_hits++;
          if (want.resolve_stage) n_late++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tlbp_pkg::REG_HISTORY_BITS: begin
            hist_len_reg = cfg_data_i;
            clear_counters();
          end
          tlbp_pkg::REG_COUNTER_BITS: begin
            ctr_len_reg = cfg_data_i;
            clear_counters();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        instr = {s_axis_tdata[$bits(tlbp_pkg::item_t)-2:0], s_axis_tuser};
        predict_outcome(instr, want);
        outcomes.push_back(want);
      end
    end
    errors_o  <= n_err;
    pending_o <= outcomes.size();
    results_o <= n_results;
    hits_o    <= n_hits;
    late_o    <= n_late;
  end

endmodule

FILE: bench/two_level_branch_predictor_btb_unit_test.sv
// Top of the branch predictor bench: clock, reset, instruction stream, output
// back-pressure and register writes across several predictor settings.
// Depends on tlbp_pkg, the unit and two_level_branch_predictor_btb_checker.
`timescale 1ns / 1ps

module two_level_branch_predictor_btb_unit_test;

  localparam int POOL       = 12;
  localparam int ADDR_W     = tlbp_pkg::ADDR_W;
  localparam int SIZE_W     = tlbp_pkg::SIZE_W;
  localparam int STAMP_W    = tlbp_pkg::STAMP_W;
  localparam int IN_DATA_W  = tlbp_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = tlbp_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W  = tlbp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = tlbp_pkg::CFG_DATA_W;
  localparam int ITEM_W     = $bits(tlbp_pkg::item_t);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int err_cnt, pending_cnt, result_cnt, hit_cnt, late_cnt;
  int n_writes = 0;

  bit gaps_on   = 1'b1;
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;

  logic [ADDR_W-1:0]  hot_addr [POOL];
  logic [SIZE_W-1:0]  hot_size [POOL];
  int                 hot_trip [POOL];
  int                 hot_iter [POOL];
  logic [STAMP_W-1:0] clock_now = 64'd100;

  always #4 clk_i = ~clk_i;

  two_level_branch_predictor_btb_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  two_level_branch_predictor_btb_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (err_cnt),
    .pending_o    (pending_cnt),
    .results_o    (result_cnt),
    .hits_o       (hit_cnt),
    .late_o       (late_cnt)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic tlbp_pkg::item_t rand_item();
    tlbp_pkg::item_t it;
    it.is_branch      = 1'($urandom_range(0, 1));
    it.branch_address = rand64();
    it.instr_size     = SIZE_W'($urandom_range(0, 15));
    it.next_address   = rand64();
    it.cycle          = rand64();
    return it;
  endfunction

  function automatic tlbp_pkg::item_t make_branch(input logic [ADDR_W-1:0] addr,
                                                  input logic [SIZE_W-1:0] size,
                                                  input bit taken,
                                                  input logic [STAMP_W-1:0] stamp);
    tlbp_pkg::item_t it;
    logic [63:0]     jump;
    jump = $urandom_range(0, 1) ? -64'($urandom_range(1, 4096)) : rand64();
    if (jump == 0) jump = 64'd1;
    it.is_branch      = 1'b1;
    it.branch_address = addr;
    it.instr_size     = size;
    it.next_address   = addr + ADDR_W'(size) + (taken ? jump : 64'd0);
    it.cycle          = stamp;
    return it;
  endfunction

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= gaps_on ? ($urandom_range(0, 99) >= 29) : 1'b1;
      end
    end
  end

  // Enter and leave at a falling edge; valid stays high after the beat.
  task automatic send_beat(input tlbp_pkg::item_t it);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.is_branch;
    s_axis_tdata  <= {{(IN_DATA_W - ITEM_W + 1){1'b0}}, it[ITEM_W-1:1]};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_writes++;
  endtask

  task automatic refill_pool();
    logic [7:0]       sets [3];
    logic [ADDR_W-1:0] tag;
    for (int i = 0; i < 3; i++) sets[i] = 8'($urandom_range(0, 255));
    for (int k = 0; k < POOL; k++) begin
      case (k % 4)
        0:       tag = '0;
        1:       tag = ADDR_W'($urandom_range(1, 7));
        default: tag = rand64() >> 8;
      endcase
      hot_addr[k] = {tag[ADDR_W-9:0], sets[k % 3]};
      hot_size[k] = SIZE_W'($urandom_range(0, 15));
      hot_trip[k] = $urandom_range(1, 12);
      hot_iter[k] = 0;
    end
  endtask

  task automatic run_stream(input int n_branches, input int hold_at);
    int              sent;
    int              k;
    int              pick;
    bit              taken;
    tlbp_pkg::item_t it;
    sent = 0;
    k    = 0;
    while (sent < n_branches) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 1)) k = $urandom_range(0, POOL - 1);
        taken = hot_iter[k] + 1 < hot_trip[k];
        hot_iter[k] = taken ? hot_iter[k] + 1 : 0;
        clock_now += 64'($urandom_range(1, 3));
        it = make_branch(hot_addr[k], hot_size[k], taken, clock_now);
      end else if (pick < 80) begin
        it = rand_item();
        it.is_branch = 1'b0;
      end else if (pick < 92) begin
        it = make_branch(rand64(), SIZE_W'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)), rand64());
      end else begin
        it = make_branch(hot_addr[k], hot_size[k], 1'($urandom_range(0, 1)), rand64());
      end
      if (it.is_branch) sent++;
      if (sent == hold_at) hold_go = 1'b1;
      send_beat(it);
    end
  endtask

  task automatic run_directed();
    tlbp_pkg::item_t it;
    it = '1;
    it.is_branch = 1'b0;
    send_beat(it);
    it = '0;
    send_beat(it);
    // tag zero hits an untouched way
    send_beat(make_branch(64'h10, 4'd4, 1'b0, 64'd100));
    send_beat(make_branch(64'h10, 4'd4, 1'b1, 64'd101));
    // address plus size wraps around
    send_beat(make_branch('1, 4'd15, 1'b0, '1));
    send_beat(make_branch('1, 4'd15, 1'b1, 64'd0));
    send_beat(make_branch(64'h1234_5678, 4'd0, 1'b0, 64'd102));
    // overfill one set, then revisit the evicted and a refreshed entry
    for (int t = 1; t <= 5; t++)
      send_beat(make_branch({56'(t), 8'h22}, 4'd2, 1'b1, 64'(200 + t)));
    send_beat(make_branch({56'd1, 8'h22}, 4'd2, 1'b1, 64'd210));
    send_beat(make_branch({56'd3, 8'h22}, 4'd2, 1'b0, 64'd5));
    send_beat(make_branch({56'd6, 8'h22}, 4'd2, 1'b1, 64'd211));
    for (int t = 0; t < 6; t++)
      send_beat(make_branch(64'h4000, 4'd8, 1'b1, 64'(300 + t)));
    for (int t = 0; t < 2; t++)
      send_beat(make_branch(64'h4000, 4'd8, 1'b0, 64'(310 + t)));
  endtask

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] hb;
    logic [CFG_DATA_W-1:0] cb;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    refill_pool();
    run_stream(180, -1);
    for (int p = 1; p <= 7; p++) begin
      s_axis_tvalid <= 1'b0;
      case (p)
        1:       begin hb = 4'd1;  cb = 4'd1;  end
        2:       begin hb = 4'd12; cb = 4'd8;  end
        3:       begin hb = 4'd0;  cb = 4'd15; end
        4:       begin hb = 4'd15; cb = 4'd0;  end
        5:       begin hb = 4'd9;  cb = 4'd8;  end
        6:       begin hb = 4'd5;  cb = 4'd3;  end
        default: begin hb = 4'd12; cb = 4'd2;  end
      endcase
      gaps_on = (p != 5);
      if (p % 2) begin
        set_register(tlbp_pkg::REG_HISTORY_BITS, hb);
        set_register(tlbp_pkg::REG_COUNTER_BITS, cb);
      end else begin
        set_register(tlbp_pkg::REG_COUNTER_BITS, cb);
        set_register(tlbp_pkg::REG_HISTORY_BITS, hb);
      end
      if (p == 4) begin
        set_register(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 15)));
        set_register(REG_SPARE_B, CFG_DATA_W'($urandom_range(0, 15)));
      end
      refill_pool();
      run_stream(180, (p == 2) ? 60 : -1);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Checked %0d result beats over eight predictor settings and %0d register writes",
             result_cnt, n_writes);
    $display("  %0d BTB hits, %0d branches resolved at execute, one long output hold-off",
             hit_cnt, late_cnt);
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tlbp_pkg.sv
sv/two_level_branch_predictor_btb_unit.sv
bench/two_level_branch_predictor_btb_checker.sv
bench/two_level_branch_predictor_btb_unit_test.sv
